### design/dwc3_pkg.sv
// shared types and constants of the 3x3 depthwise convolution stream core
package dwc3_pkg;

    localparam int MAX_SIZE_DEF  = 64;
    localparam int TAP_WIDTH_DEF = 4;
    localparam int CHANNELS      = 3;
    localparam int KERNEL_TAPS   = 9;
    localparam int NUM_EMIT      = 4;

    localparam int PIX_W      = 8;
    localparam int PIX3_W     = CHANNELS * PIX_W;
    localparam int SIZE_W     = 7;
    localparam int POS_W      = 6;
    localparam int OUT_W      = 16;
    localparam int OUT_PAD_W  = 4;
    localparam int OUT_DATA_W = CHANNELS * OUT_W + 2 * POS_W + OUT_PAD_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd5;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_CH0 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_CH1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_CH2 = 2'd3;

    // which border windows a pixel releases, and their positions
    // mask bit 0: (row_a, col_a), 1: (row_a, col_b), 2: (row_b, col_a), 3: (row_b, col_b)
    typedef struct packed {
        logic [NUM_EMIT-1:0] mask;
        logic [POS_W-1:0]    row_a;
        logic [POS_W-1:0]    row_b;
        logic [POS_W-1:0]    col_a;
        logic [POS_W-1:0]    col_b;
    } emit_ctrl_t;

    typedef logic [NUM_EMIT-1:0][OUT_W-1:0] lane_sums_t;

endpackage

### design/depthwise_conv3x3_stream_core.sv
// top level of the 3x3 depthwise convolution stream core with same padding
// a pixel's results pass s1, the lane product registers and the merge stage to m_tvalid
// throughput: one pixel per cycle; results leave one per cycle, so row ends and the
// last row (two to four results per pixel) hold the input back through the merge stage
// reset: a sweep clears the line buffers, then stale_reg holds s_tready low while line data
// is read anew; image_size returns to 5, kernels to zero; config writes are taken always
module depthwise_conv3x3_stream_core
    import dwc3_pkg::*;
#(
    parameter int MAX_SIZE  = MAX_SIZE_DEF,
    parameter int TAP_WIDTH = TAP_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel_ch0 [7:0], pixel_ch1 [15:8], pixel_ch2 [23:16]
    input  logic [PIX3_W-1:0]                    s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // out_ch0 [15:0], out_ch1 [31:16], out_ch2 [47:32], out_row [53:48], out_col [59:54]
    output logic [OUT_DATA_W-1:0]                m_tdata,
    // last_of_run
    output logic                                 m_tlast,
    // frame_done
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [KERNEL_TAPS*TAP_WIDTH-1:0]     cfg_data
);

    localparam int CW    = $clog2(MAX_SIZE);
    localparam int CMP_W = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int KW    = KERNEL_TAPS * TAP_WIDTH;
    localparam logic [SIZE_W-1:0] SIZE_CAP = (MAX_SIZE > 127) ? 7'd127 : SIZE_W'(MAX_SIZE);

    // configuration
    logic [SIZE_W-1:0] size_reg;
    logic [KW-1:0]     kernel_reg [CHANNELS];
    logic              cfg_xfer;

    // position and window
    logic [CW-1:0]     row_count_reg;
    logic [CW-1:0]     row_count_next;
    logic [CW-1:0]     col_count_reg;
    logic [CW-1:0]     col_count_next;
    logic [2:0][1:0][PIX3_W-1:0] win_reg;
    logic [2:0][1:0][PIX3_W-1:0] win_next;
    logic              stale_reg;

    // pipeline
    logic              s1_valid_reg;
    logic              s1_valid_next;
    emit_ctrl_t        s1_ctrl_reg;
    logic [CHANNELS-1:0][KERNEL_TAPS-1:0][PIX_W-1:0] s1_win_reg;
    logic [CHANNELS-1:0][KERNEL_TAPS-1:0][PIX_W-1:0] s1_win_next;
    logic              s2_valid_reg;
    emit_ctrl_t        s2_ctrl_reg;

    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W-1:0] size_m1;
    logic              restart;
    logic [CW-1:0]     r_eff;
    logic [CW-1:0]     c_eff;
    logic              r_last;
    logic              c_last;
    logic [CW-1:0]     next_r;
    logic [CW-1:0]     next_c;
    logic [2:0][2:0][PIX3_W-1:0] g;
    emit_ctrl_t        emit;

    logic              in_xfer;
    logic              move2;
    logic              move3;
    logic              can_load;
    logic              lb_busy;
    logic [PIX3_W-1:0] rd_upper;
    logic [PIX3_W-1:0] rd_middle;
    logic [CW-1:0]     rd_addr;
    lane_sums_t [CHANNELS-1:0] lane_sums;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                kernel_reg[ch] <= '0;
            end
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_IMAGE_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                REG_KERNEL_CH0: kernel_reg[0] <= cfg_data;
                REG_KERNEL_CH1: kernel_reg[1] <= cfg_data;
                REG_KERNEL_CH2: kernel_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // size clamp and frame restart when the position falls outside a new size
    always_comb
    begin
        if (size_reg < SIZE_MIN)
        begin
            size_eff = SIZE_MIN;
        end
        else if (size_reg > SIZE_CAP)
        begin
            size_eff = SIZE_CAP;
        end
        else
        begin
            size_eff = size_reg;
        end
        size_m1 = size_eff - SIZE_W'(1);
        restart = (CMP_W'(row_count_reg) >= CMP_W'(size_eff)) ||
                  (CMP_W'(col_count_reg) >= CMP_W'(size_eff));
        r_eff   = restart ? '0 : row_count_reg;
        c_eff   = restart ? '0 : col_count_reg;
        r_last  = (CMP_W'(r_eff) == CMP_W'(size_m1));
        c_last  = (CMP_W'(c_eff) == CMP_W'(size_m1));
        next_c  = c_last ? '0 : c_eff + CW'(1);
        if (!c_last)
        begin
            next_r = r_eff;
        end
        else if (r_last)
        begin
            next_r = '0;
        end
        else
        begin
            next_r = r_eff + CW'(1);
        end
    end

    // 3x3 window; top rows and left columns outside the image read as zero
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g[i][0] = (c_eff == '0) ? '0 : win_reg[i][0];
            g[i][1] = (c_eff == '0) ? '0 : win_reg[i][1];
        end
        g[0][2] = (r_eff >= CW'(2)) ? rd_upper : '0;
        g[1][2] = (r_eff != '0) ? rd_middle : '0;
        g[2][2] = s_tdata;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = g[i][1];
            win_next[i][1] = g[i][2];
        end
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    s1_win_next[ch][m*3+n] = g[m][n][PIX_W*ch +: PIX_W];
                end
            end
        end
        emit.mask[0] = (r_eff != '0) && (c_eff != '0);
        emit.mask[1] = (r_eff != '0) && c_last;
        emit.mask[2] = r_last && (c_eff != '0);
        emit.mask[3] = r_last && c_last;
        emit.row_a   = POS_W'(r_eff - CW'(1));
        emit.row_b   = POS_W'(r_eff);
        emit.col_a   = POS_W'(c_eff - CW'(1));
        emit.col_b   = POS_W'(c_eff);
    end

    assign move3    = s2_valid_reg && can_load;
    assign move2    = s1_valid_reg && (!s2_valid_reg || move3);
    assign s_tready = !lb_busy && !stale_reg && (!s1_valid_reg || move2);
    assign in_xfer  = s_tvalid && s_tready;

    // prefetch the next column so its line data is ready at the next transfer
    assign rd_addr        = in_xfer ? next_c : c_eff;
    assign row_count_next = in_xfer ? next_r : row_count_reg;
    assign col_count_next = in_xfer ? next_c : col_count_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = (emit.mask != '0);
        end
        else if (move2)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            win_reg       <= '0;
            stale_reg     <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            if (in_xfer)
            begin
                win_reg <= win_next;
            end
            // stale_reg blocks input in the cycle after a sweep or config write, while line data is read anew
            stale_reg    <= lb_busy || cfg_xfer;
            s1_valid_reg <= s1_valid_next;
            if (move2)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (move3)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ctrl_reg <= emit;
            s1_win_reg  <= s1_win_next;
        end
        if (move2)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    dwc3_linebuf #(
        .MAX_SIZE (MAX_SIZE)
    ) u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_xfer),
        .wr_addr   (c_eff),
        .wr_upper  (rd_middle),
        .wr_middle (s_tdata),
        .rd_addr   (rd_addr),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .busy      (lb_busy)
    );

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        dwc3_lane #(
            .TAP_WIDTH (TAP_WIDTH)
        ) u_lane (
            .clk    (clk),
            .en     (move2),
            .win    (s1_win_reg[ch]),
            .kernel (kernel_reg[ch]),
            .sums   (lane_sums[ch])
        );
    end

    dwc3_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move3),
        .lane_sums (lane_sums),
        .ctrl      (s2_ctrl_reg),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // no pixel is taken while the line buffers are still being cleared
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        lb_busy |-> !s_tready)
        else $error("pixel accepted during line buffer sweep");

    // the last column of a row wraps the column count
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && c_last |=> col_count_reg == '0)
        else $error("column count did not wrap at row end");

    // the end of a frame is always the last result of its pixel
    a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done without last_of_run");

endmodule

### design/dwc3_linebuf.sv
// two line buffer memories with a registered read port and a clearing sweep after reset
module dwc3_linebuf
    import dwc3_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_SIZE)-1:0]   wr_addr,
    input  logic [PIX3_W-1:0]             wr_upper,
    input  logic [PIX3_W-1:0]             wr_middle,
    input  logic [$clog2(MAX_SIZE)-1:0]   rd_addr,
    output logic [PIX3_W-1:0]             rd_upper,
    output logic [PIX3_W-1:0]             rd_middle,
    output logic                          busy
);

    localparam int ADDR_W = $clog2(MAX_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SIZE - 1);

    logic [PIX3_W-1:0] upper_mem [MAX_SIZE];
    logic [PIX3_W-1:0] middle_mem [MAX_SIZE];

    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic [PIX3_W-1:0] rd_upper_reg;
    logic [PIX3_W-1:0] rd_middle_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            upper_mem[clr_addr_reg]  <= '0;
            middle_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        rd_upper_reg  <= upper_mem[rd_addr];
        rd_middle_reg <= middle_mem[rd_addr];
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;
    assign busy      = clearing_reg;

endmodule

### design/dwc3_lane.sv
// one channel lane: registered tap products and the four window sums
module dwc3_lane
    import dwc3_pkg::*;
#(
    parameter int TAP_WIDTH = TAP_WIDTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [KERNEL_TAPS-1:0][PIX_W-1:0]    win,
    input  logic [KERNEL_TAPS*TAP_WIDTH-1:0]     kernel,
    output lane_sums_t                           sums
);

    localparam int PW = TAP_WIDTH + PIX_W + 1;
    localparam int SW = PW + 4;

    logic signed [PW-1:0] full_reg   [9];
    logic signed [PW-1:0] right_reg  [6];
    logic signed [PW-1:0] down_reg   [6];
    logic signed [PW-1:0] corner_reg [4];

    function automatic logic signed [PW-1:0] mul_tap(input logic [PIX_W-1:0] px,
                                                     input logic [TAP_WIDTH-1:0] tap);
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
        a = $signed({{(PW-PIX_W){1'b0}}, px});
        b = PW'($signed(tap));
        return a * b;
    endfunction

    // windows shifted right or down see zero padding in the missing column or row
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 3; m++)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    full_reg[m*3+n] <= mul_tap(win[m*3+n],
                                               kernel[TAP_WIDTH*(m*3+n) +: TAP_WIDTH]);
                end
            end
            for (int m = 0; m < 3; m++)
            begin
                for (int n = 0; n < 2; n++)
                begin
                    right_reg[m*2+n] <= mul_tap(win[m*3+n+1],
                                                kernel[TAP_WIDTH*(m*3+n) +: TAP_WIDTH]);
                end
            end
            for (int m = 0; m < 2; m++)
            begin
                for (int n = 0; n < 3; n++)
                begin
                    down_reg[m*3+n] <= mul_tap(win[(m+1)*3+n],
                                               kernel[TAP_WIDTH*(m*3+n) +: TAP_WIDTH]);
                end
            end
            for (int m = 0; m < 2; m++)
            begin
                for (int n = 0; n < 2; n++)
                begin
                    corner_reg[m*2+n] <= mul_tap(win[(m+1)*3+n+1],
                                                 kernel[TAP_WIDTH*(m*3+n) +: TAP_WIDTH]);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] acc_full;
        logic signed [SW-1:0] acc_right;
        logic signed [SW-1:0] acc_down;
        logic signed [SW-1:0] acc_corner;
        acc_full   = '0;
        acc_right  = '0;
        acc_down   = '0;
        acc_corner = '0;
        for (int t = 0; t < 9; t++)
        begin
            acc_full = acc_full + SW'(full_reg[t]);
        end
        for (int t = 0; t < 6; t++)
        begin
            acc_right = acc_right + SW'(right_reg[t]);
            acc_down  = acc_down + SW'(down_reg[t]);
        end
        for (int t = 0; t < 4; t++)
        begin
            acc_corner = acc_corner + SW'(corner_reg[t]);
        end
        sums[0] = acc_full[OUT_W-1:0];
        sums[1] = acc_right[OUT_W-1:0];
        sums[2] = acc_down[OUT_W-1:0];
        sums[3] = acc_corner[OUT_W-1:0];
    end

endmodule

### design/dwc3_merge.sv
// merging stage: holds the lane sums of one pixel and sends its results one per transfer
module dwc3_merge
    import dwc3_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  lane_sums_t [CHANNELS-1:0]   lane_sums,
    input  emit_ctrl_t                  ctrl,
    output logic                        can_load,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    lane_sums_t [CHANNELS-1:0] sums_reg;
    emit_ctrl_t                ctrl_reg;
    logic [NUM_EMIT-1:0]       mask_reg;
    logic [NUM_EMIT-1:0]       mask_next;

    logic [1:0]                sel;
    logic [NUM_EMIT-1:0]       remaining;
    logic                      last;
    logic                      out_xfer;
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;

    // lowest pending window first, which is raster order
    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
        remaining = mask_reg & ~(NUM_EMIT'(1) << sel);
    end

    assign last     = (remaining == '0);
    assign m_tvalid = (mask_reg != '0);
    assign out_xfer = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (m_tready && last);

    assign out_row = sel[1] ? ctrl_reg.row_b : ctrl_reg.row_a;
    assign out_col = sel[0] ? ctrl_reg.col_b : ctrl_reg.col_a;

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_col, out_row,
                      sums_reg[2][sel], sums_reg[1][sel], sums_reg[0][sel]};
    assign m_tlast = last;
    // only the bottom-right window of the last pixel ends the frame
    assign m_tuser = (sel == 2'd3);

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = ctrl.mask;
        end
        else if (out_xfer)
        begin
            mask_next = remaining;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sums_reg <= lane_sums;
            ctrl_reg <= ctrl;
        end
    end

endmodule
